// File: rtl/rsg_pkg.sv
// ============================================================================
// rsg_pkg
// Shared types and constants for the road scanline generator.
// ============================================================================
package rsg_pkg;

    localparam int          ROM_DEPTH    = 128;
    localparam int          ROM_IDX_W    = 7;
    localparam int          ROM_W        = 11;
    localparam int          RECIP_NUM    = -1000;

    localparam logic [15:0] ROW_START    = 16'hFF00;
    localparam logic [15:0] ROW_STEP     = 16'(32'hF800 / 128);
    localparam logic [15:0] SCROLL_BASE  = 16'(480 - 160);
    localparam logic [7:0]  VSCROLL_BIAS = 8'd32;
    localparam logic [7:0]  WIPED_ROW    = 8'hFF;

    localparam int          CFG_IDX_W    = 2;
    localparam logic [CFG_IDX_W-1:0] REG_ROAD_X_OFFSET  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CURVE_RATE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_POSITION = 2'd2;

    typedef struct packed {
        logic                 frame_start;
        logic                 road;
        logic [ROM_IDX_W-1:0] rom_idx;
        logic [7:0]           line_index;
        logic                 last;
    } cmd_t;

    typedef struct packed {
        logic [7:0]  line_index;
        logic [7:0]  screen_row;
        logic [15:0] x_scroll;
        logic        stripe_colour;
        logic [5:0]  bank_byte;
        logic [6:0]  fine_scroll_byte;
        logic [7:0]  vertical_scroll_byte;
        logic        last_of_frame;
    } res_t;

endpackage

// File: rtl/road_scanline_generator_core.sv
// ============================================================================
// road_scanline_generator_core
// Pseudo-3D road line generator: one display-list result per line tick.
// ============================================================================
// A tick waits in the command queue and its result in the result queue.
// Throughput: one line per cycle while neither queue is full.
// Queues of four entries sit between the sequencer, datapath and output.
// Reset empties both queues, clears the control registers and arms a frame
// start for the next tick; the line accumulators load at that frame start.
module road_scanline_generator_core
    import rsg_pkg::*;
#(
    parameter int LINE_COUNT  = 200,
    parameter int DEPTH_STEPS = 128
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic                 restart_frame,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    output logic                 empty,
    input  logic                 pop,
    output logic [7:0]           line_index,
    output logic [7:0]           screen_row,
    output logic signed [15:0]   x_scroll,
    output logic                 stripe_colour,
    output logic [5:0]           bank_byte,
    output logic [6:0]           fine_scroll_byte,
    output logic [7:0]           vertical_scroll_byte,
    output logic                 last_of_frame
);

    logic in_accept;
    cmd_t cmd_in;
    cmd_t cmd_out;
    logic cmd_empty;
    logic cmd_pop;
    res_t res_in;
    res_t res_out;
    logic res_full;
    logic res_push;

    assign cfg_ready = 1'b1;
    assign in_accept = push && !full;
    assign res_push  = cmd_pop;

    rsg_front #(
        .LINE_COUNT  (LINE_COUNT),
        .DEPTH_STEPS (DEPTH_STEPS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (in_accept),
        .restart_frame (restart_frame),
        .cmd           (cmd_in)
    );

    rsg_fifo #(
        .WIDTH  ($bits(cmd_t)),
        .ADDR_W (2)
    ) u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (in_accept),
        .wr_data (cmd_in),
        .full    (full),
        .rd_en   (cmd_pop),
        .rd_data (cmd_out),
        .empty   (cmd_empty)
    );

    rsg_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (!cmd_empty),
        .cmd       (cmd_out),
        .res_full  (res_full),
        .cmd_pop   (cmd_pop),
        .res       (res_in)
    );

    rsg_fifo #(
        .WIDTH  ($bits(res_t)),
        .ADDR_W (2)
    ) u_res_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_in),
        .full    (res_full),
        .rd_en   (pop && !empty),
        .rd_data (res_out),
        .empty   (empty)
    );

    assign line_index           = res_out.line_index;
    assign screen_row           = res_out.screen_row;
    assign x_scroll             = res_out.x_scroll;
    assign stripe_colour        = res_out.stripe_colour;
    assign bank_byte            = res_out.bank_byte;
    assign fine_scroll_byte     = res_out.fine_scroll_byte;
    assign vertical_scroll_byte = res_out.vertical_scroll_byte;
    assign last_of_frame        = res_out.last_of_frame;

endmodule

// File: rtl/rsg_fifo.sv
// ============================================================================
// rsg_fifo
// Small synchronous queue; power-of-two depth, read data shown while not empty.
// ============================================================================
module rsg_fifo #(
    parameter int WIDTH  = 8,
    parameter int ADDR_W = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int DEPTH = 2 ** ADDR_W;

    logic [WIDTH-1:0]  mem [DEPTH];
    logic [ADDR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [ADDR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [ADDR_W:0]   count_reg, count_next;

    assign full    = (count_reg == (ADDR_W+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + ADDR_W'(wr_en);
        rd_ptr_next = rd_ptr_reg + ADDR_W'(rd_en);
        count_next  = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + (ADDR_W+1)'(1);
        end
        else if (!wr_en && rd_en)
        begin
            count_next = count_reg - (ADDR_W+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && full))
        else $error("write into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(rd_en && empty))
        else $error("read from empty queue");

endmodule

// File: rtl/rsg_front.sv
// ============================================================================
// rsg_front
// Line sequencer: tracks line and depth counters and classifies each line.
// ============================================================================
module rsg_front
    import rsg_pkg::*;
#(
    parameter int LINE_COUNT  = 200,
    parameter int DEPTH_STEPS = 128
) (
    input  logic clk,
    input  logic rst_n,
    input  logic accept,
    input  logic restart_frame,
    output cmd_t cmd
);

    logic       pending_reg, pending_next;
    logic [7:0] line_reg, line_next;
    logic [7:0] depth_reg, depth_next;
    logic       frame_start;
    logic [7:0] line_cur;
    logic [7:0] depth_cur;
    logic [7:0] depth_dec;
    logic       road;

    always_comb
    begin
        frame_start = restart_frame || pending_reg;
        line_cur    = frame_start ? 8'(LINE_COUNT - 1) : line_reg;
        depth_cur   = frame_start ? 8'(DEPTH_STEPS) : depth_reg;
        depth_dec   = depth_cur - 8'd1;
        road        = (depth_cur != 8'd0);

        cmd.frame_start = frame_start;
        cmd.road        = road;
        cmd.rom_idx     = depth_dec[ROM_IDX_W-1:0];
        cmd.line_index  = line_cur;
        cmd.last        = (line_cur == 8'd0);

        pending_next = pending_reg;
        line_next    = line_reg;
        depth_next   = depth_reg;
        if (accept)
        begin
            pending_next = (line_cur == 8'd0);
            line_next    = line_cur - 8'd1;
            depth_next   = road ? depth_dec : depth_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b1;
            line_reg    <= 8'(LINE_COUNT - 1);
            depth_reg   <= 8'(DEPTH_STEPS);
        end
        else
        begin
            pending_reg <= pending_next;
            line_reg    <= line_next;
            depth_reg   <= depth_next;
        end
    end

    a_frame_ends: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (line_cur == 8'd0) |=> pending_reg)
        else $error("frame did not close after line zero");

endmodule

// File: rtl/rsg_back.sv
// ============================================================================
// rsg_back
// Line datapath: row, lateral and curve accumulators, stripe lookup, packing.
// ============================================================================
module rsg_back
    import rsg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic                 cmd_valid,
    input  cmd_t                 cmd,
    input  logic                 res_full,
    output logic                 cmd_pop,
    output res_t                 res
);

    logic [ROM_W-1:0] recip_rom [ROM_DEPTH];

    for (genvar k = 0; k < ROM_DEPTH; k++)
    begin : g_rom
        localparam int RecipVal = RECIP_NUM / (k + 1);
        assign recip_rom[k] = RecipVal[ROM_W-1:0];
    end

    logic [31:0] offset_reg, offset_next;
    logic [31:0] rate_reg, rate_next;
    logic [31:0] dpos_reg, dpos_next;
    logic [31:0] slope_cfg_reg, slope_cfg_next;
    logic [31:0] diff_cfg_reg, diff_cfg_next;
    logic [31:0] slope_frame_reg, slope_frame_next;
    logic [31:0] diff_frame_reg, diff_frame_next;
    logic [15:0] row_acc_reg, row_acc_next;
    logic [31:0] lat_acc_reg, lat_acc_next;
    logic [31:0] curve_acc_reg, curve_acc_next;

    logic [31:0] biased;
    logic [15:0] row_cur;
    logic [31:0] lat_cur;
    logic [31:0] curve_cur;
    logic [31:0] diff_cur;
    logic [3:0]  stripe_sum;
    logic [7:0]  row_out;
    logic [15:0] scroll_out;
    logic        colour_out;

    always_comb
    begin
        offset_next      = offset_reg;
        rate_next        = rate_reg;
        dpos_next        = dpos_reg;
        slope_cfg_next   = slope_cfg_reg;
        diff_cfg_next    = diff_cfg_reg;
        slope_frame_next = slope_frame_reg;
        diff_frame_next  = diff_frame_reg;
        biased           = cfg_data + {25'd0, {7{cfg_data[31]}}};

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ROAD_X_OFFSET:
                begin
                    offset_next    = cfg_data;
                    slope_cfg_next = {{7{biased[31]}}, biased[31:7]};
                    diff_cfg_next  = rate_reg - slope_cfg_next;
                end
                REG_CURVE_RATE:
                begin
                    rate_next       = cfg_data;
                    diff_cfg_next   = cfg_data - slope_cfg_reg;
                    diff_frame_next = cfg_data - slope_frame_reg;
                end
                REG_DEPTH_POSITION:
                begin
                    dpos_next = cfg_data;
                end
                default:
                begin
                    dpos_next = dpos_reg;
                end
            endcase
        end

        cmd_pop   = cmd_valid && !res_full;
        row_cur   = cmd.frame_start ? ROW_START : row_acc_reg;
        lat_cur   = cmd.frame_start ? offset_reg : lat_acc_reg;
        curve_cur = cmd.frame_start ? 32'd0 : curve_acc_reg;
        diff_cur  = cmd.frame_start ? diff_cfg_reg : diff_frame_reg;

        row_acc_next   = row_acc_reg;
        lat_acc_next   = lat_acc_reg;
        curve_acc_next = curve_acc_reg;

        if (cmd_pop && cmd.frame_start)
        begin
            slope_frame_next = slope_cfg_reg;
            diff_frame_next  = diff_cfg_reg;
        end

        if (cmd_pop && cmd.road)
        begin
            row_acc_next   = row_cur - ROW_STEP;
            curve_acc_next = curve_cur + rate_reg;
            lat_acc_next   = lat_cur + curve_cur + diff_cur;
        end

        stripe_sum = recip_rom[cmd.rom_idx][3:0] - dpos_reg[3:0];
        row_out    = cmd.road ? row_cur[15:8] : WIPED_ROW;
        scroll_out = cmd.road ? (SCROLL_BASE + lat_cur[31:16]) : 16'd0;
        colour_out = cmd.road && !stripe_sum[3];

        res.line_index           = cmd.line_index;
        res.screen_row           = row_out;
        res.x_scroll             = scroll_out;
        res.stripe_colour        = colour_out;
        res.bank_byte            = {1'b1, colour_out, scroll_out[9:6]};
        res.fine_scroll_byte     = {1'b1, scroll_out[5:0]};
        res.vertical_scroll_byte = row_out - VSCROLL_BIAS - cmd.line_index;
        res.last_of_frame        = cmd.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg      <= '0;
            rate_reg        <= '0;
            dpos_reg        <= '0;
            slope_cfg_reg   <= '0;
            diff_cfg_reg    <= '0;
            slope_frame_reg <= '0;
            diff_frame_reg  <= '0;
        end
        else
        begin
            offset_reg      <= offset_next;
            rate_reg        <= rate_next;
            dpos_reg        <= dpos_next;
            slope_cfg_reg   <= slope_cfg_next;
            diff_cfg_reg    <= diff_cfg_next;
            slope_frame_reg <= slope_frame_next;
            diff_frame_reg  <= diff_frame_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_acc_reg   <= row_acc_next;
        lat_acc_reg   <= lat_acc_next;
        curve_acc_reg <= curve_acc_next;
    end

    a_row_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop && cmd.frame_start && cmd.road |=> row_acc_reg == (ROW_START - ROW_STEP))
        else $error("row accumulator not restarted at frame start");

    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |-> !cmd_valid)
        else $error("configuration write while lines are in flight");

endmodule

// File: bench/tb_top.sv
// ============================================================================
// tb_top - road scanline generator core testbench
// Drives line ticks through the push/full queue port and pops line results.
// A scoreboard class predicts each line from its own copy of the frame
// accumulators and the control registers, and checks every popped beat in
// order. Registers are rewritten between phases once the block has drained.
// ============================================================================
module tb_top
    import rsg_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_COUNT  = 200;
    localparam int DEPTH_STEPS = 128;
    localparam int ITEM_TARGET = 1500;
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 80;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    class line_scoreboard;
        int          line_count;
        int          depth_steps;
        logic [31:0] recip [ROM_DEPTH];
        logic [31:0] x_offset;
        logic [31:0] curve_rate;
        logic [31:0] depth_pos;
        logic [7:0]  line_ctr;
        logic [15:0] row_acc;
        logic [31:0] lat_acc;
        logic [31:0] curve_acc;
        logic [31:0] slope;
        int          depth_ctr;
        bit          frame_due;
        res_t        expected_q[$];
        int          mismatches;

        function new(int lines, int depths);
            line_count  = lines;
            depth_steps = depths;
            for (int k = 0; k < ROM_DEPTH; k++)
                recip[k] = 32'(RECIP_NUM / (k + 1));
            x_offset   = '0;
            curve_rate = '0;
            depth_pos  = '0;
            mismatches = 0;
            begin_frame();
            frame_due = 1'b1;
        endfunction

        function void begin_frame();
            line_ctr  = 8'(line_count - 1);
            row_acc   = ROW_START;
            lat_acc   = x_offset;
            curve_acc = '0;
            slope     = 32'($signed(x_offset) / 128);
            depth_ctr = depth_steps;
            frame_due = 1'b0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
            case (idx)
                REG_ROAD_X_OFFSET:  x_offset   = data;
                REG_CURVE_RATE:     curve_rate = data;
                REG_DEPTH_POSITION: depth_pos  = data;
                default: ;
            endcase
        endfunction

        function void note_line(bit restart);
            res_t        r;
            logic [31:0] diff;
            logic [7:0]  line;
            if (restart || frame_due)
                begin_frame();
            line = line_ctr;
            if (depth_ctr != 0)
            begin
                diff            = recip[depth_ctr - 1] - depth_pos;
                r.screen_row    = row_acc[15:8];
                r.x_scroll      = SCROLL_BASE + lat_acc[31:16];
                r.stripe_colour = ~diff[3];
                row_acc         = row_acc - ROW_STEP;
                curve_acc       = curve_acc + curve_rate;
                lat_acc         = lat_acc + curve_acc - slope;
                depth_ctr--;
            end
            else
            begin
                r.screen_row    = WIPED_ROW;
                r.x_scroll      = '0;
                r.stripe_colour = 1'b0;
            end
            r.line_index           = line;
            r.bank_byte            = 6'h20 + {2'b00, r.x_scroll[9:6]}
                                     + (r.stripe_colour ? 6'h10 : 6'h00);
            r.fine_scroll_byte     = 7'h40 + {1'b0, r.x_scroll[5:0]};
            r.vertical_scroll_byte = r.screen_row - VSCROLL_BIAS - line;
            r.last_of_frame        = (line == 8'd0);
            if (line == 8'd0)
                frame_due = 1'b1;
            else
                line_ctr = line - 8'd1;
            expected_q.push_back(r);
        endfunction

        function void check_line(res_t got);
            res_t exp_r;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected line beat, line %0d", $realtime,
                             got.line_index);
                return;
            end
            exp_r = expected_q.pop_front();
            if (got.line_index !== exp_r.line_index
                || got.screen_row !== exp_r.screen_row
                || got.x_scroll !== exp_r.x_scroll
                || got.stripe_colour !== exp_r.stripe_colour
                || got.bank_byte !== exp_r.bank_byte
                || got.fine_scroll_byte !== exp_r.fine_scroll_byte
                || got.vertical_scroll_byte !== exp_r.vertical_scroll_byte
                || got.last_of_frame !== exp_r.last_of_frame)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("%0t: expected line %0d row %0d scroll %h col %b",
                             $realtime, exp_r.line_index, exp_r.screen_row,
                             exp_r.x_scroll, exp_r.stripe_colour);
                    $display("    expected bank %h fine %h vs %h last %b",
                             exp_r.bank_byte, exp_r.fine_scroll_byte,
                             exp_r.vertical_scroll_byte, exp_r.last_of_frame);
                    $display("%0t: actual   line %0d row %0d scroll %h col %b",
                             $realtime, got.line_index, got.screen_row,
                             got.x_scroll, got.stripe_colour);
                    $display("    actual   bank %h fine %h vs %h last %b",
                             got.bank_byte, got.fine_scroll_byte,
                             got.vertical_scroll_byte, got.last_of_frame);
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 push;
    logic                 full;
    logic                 restart_frame;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;
    logic                 empty;
    logic                 pop;
    logic [7:0]           line_index;
    logic [7:0]           screen_row;
    logic signed [15:0]   x_scroll;
    logic                 stripe_colour;
    logic [5:0]           bank_byte;
    logic [6:0]           fine_scroll_byte;
    logic [7:0]           vertical_scroll_byte;
    logic                 last_of_frame;

    line_scoreboard lines;
    int             items_sent;
    int             quiet_cycles;
    int             hold_left;
    bit             hold_taken;
    logic           hold_request;
    logic           calm;

    road_scanline_generator_core #(
        .LINE_COUNT  (LINE_COUNT),
        .DEPTH_STEPS (DEPTH_STEPS)
    ) i_dut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .push                 (push),
        .full                 (full),
        .restart_frame        (restart_frame),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .empty                (empty),
        .pop                  (pop),
        .line_index           (line_index),
        .screen_row           (screen_row),
        .x_scroll             (x_scroll),
        .stripe_colour        (stripe_colour),
        .bank_byte            (bank_byte),
        .fine_scroll_byte     (fine_scroll_byte),
        .vertical_scroll_byte (vertical_scroll_byte),
        .last_of_frame        (last_of_frame)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
            begin : take_beat
                res_t got;
                got.line_index           = line_index;
                got.screen_row           = screen_row;
                got.x_scroll             = x_scroll;
                got.stripe_colour        = stripe_colour;
                got.bank_byte            = bank_byte;
                got.fine_scroll_byte     = fine_scroll_byte;
                got.vertical_scroll_byte = vertical_scroll_byte;
                got.last_of_frame        = last_of_frame;
                lines.check_line(got);
            end
            if (hold_request && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
                pop <= calm || ($urandom_range(0, 99) >= 16);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("FAIL road_scanline_generator_core");
                $finish;
            end
        end
    end

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'hFFFF_FFFF;
            4:       return 32'hFFFF_FF81;
            5:       return 32'($urandom_range(0, 8192)) - 32'd4096;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_line(bit restart);
        push          <= 1'b1;
        restart_frame <= restart;
        do @(posedge clk); while (full);
        lines.note_line(restart);
        items_sent++;
    endtask

    task automatic idle_gap();
        push          <= 1'b0;
        restart_frame <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
    endtask

    task automatic drain();
        push          <= 1'b0;
        restart_frame <= 1'b0;
        cfg_valid     <= 1'b0;
        do @(posedge clk); while (lines.pending() != 0);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        lines.write_reg(idx, data);
    endtask

    initial
    begin
        int n;
        int phase;
        int restart_odds;
        lines         = new(LINE_COUNT, DEPTH_STEPS);
        items_sent    = 0;
        quiet_cycles  = 0;
        hold_left     = 0;
        hold_taken    = 1'b0;
        hold_request  = 1'b0;
        calm          = 1'b0;
        rst_n         = 1'b0;
        push          = 1'b0;
        restart_frame = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_ROAD_X_OFFSET;
        cfg_data      = '0;
        pop           = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_line(1'b0);
        send_line(1'b0);
        send_line(1'b1);
        send_line(1'b0);
        drain();
        write_reg(REG_ROAD_X_OFFSET, 32'h7FFF_FFFF);
        write_reg(REG_CURVE_RATE, 32'h8000_0000);
        write_reg(REG_DEPTH_POSITION, 32'hFFFF_FFFF);
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        cfg_valid <= 1'b0;
        send_line(1'b1);
        repeat (7) send_line(1'b0);
        drain();
        write_reg(REG_ROAD_X_OFFSET, 32'h8000_0000);
        write_reg(REG_CURVE_RATE, 32'h7FFF_FFFF);
        write_reg(REG_DEPTH_POSITION, 32'h0000_0000);
        write_reg(REG_UNUSED, 32'h0000_0000);
        cfg_valid <= 1'b0;
        repeat (4) send_line(1'b0);
        send_line(1'b1);
        repeat (4) send_line(1'b0);

        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            drain();
            write_reg(REG_ROAD_X_OFFSET, pick_word());
            if ($urandom_range(0, 1) == 1)
                write_reg(REG_CURVE_RATE, pick_word());
            write_reg(REG_DEPTH_POSITION, pick_word());
            if ($urandom_range(0, 3) == 0)
                write_reg(REG_UNUSED, $urandom);
            cfg_valid    <= 1'b0;
            hold_request <= (phase == 1);
            calm         <= (phase == 2);
            restart_odds = (phase % 4 == 3) ? 20 : 200;
            n = $urandom_range(120, 320);
            repeat (n)
            begin
                if (phase != 2 && $urandom_range(0, 99) < 16)
                    idle_gap();
                send_line($urandom_range(1, restart_odds) == 1);
            end
            phase++;
        end

        drain();
        repeat (8) @(posedge clk);
        if (lines.mismatches == 0 && lines.pending() == 0)
            $display("PASS road_scanline_generator_core");
        else
            $display("FAIL road_scanline_generator_core");
        $finish;
    end
endmodule
